@@ rtl/core/chm_pkg.sv @@
// Shared types and constants of the chained hash map engine.
// No dependencies; imported by every module of the block.
package chm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_BUCKETS = 2048;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int NODE_AW     = 10;
    localparam int PTR_W       = 11;
    localparam int BKT_AW      = 11;
    localparam int CNT_W       = 11;
    localparam int CAP_W       = 12;
    localparam int LOG_W       = 4;

    localparam logic [PTR_W-1:0] NIL      = PTR_W'(MAX_ENTRIES);
    localparam logic [LOG_W-1:0] LOG2_MAX = LOG_W'(BKT_AW);

    // operation codes on the input
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CKEY   = 3'd3;
    localparam logic [2:0] OP_CVAL   = 3'd4;

    // command kinds after classification
    localparam logic [2:0] K_WRITE  = 3'd0;
    localparam logic [2:0] K_READ   = 3'd1;
    localparam logic [2:0] K_REMOVE = 3'd2;
    localparam logic [2:0] K_CKEY   = 3'd3;
    localparam logic [2:0] K_CVAL   = 3'd4;
    localparam logic [2:0] K_NOP    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] key;
        logic signed [31:0] data_value;
    } item_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_data;
        logic [1:0]         status;
        logic [10:0]        entry_count;
        logic [11:0]        bucket_capacity;
    } result_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } cmd_t;

    // front to back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fq_t;

    // back to front
    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_t;

endpackage

@@ rtl/core/chained_hash_map_engine.sv @@
// Top level of the chained hash map engine: front queue plus back sequencer.
// Depends on chm_pkg, chm_front and chm_back.
//
// Usage:
//   Operation transfer: item (op, key, data_value) is taken at a clock edge
//   with start high and busy low. A two-entry queue decouples the front from
//   the back, so up to two operations may wait while one executes.
//   Result: done pulses for one cycle with result valid; the receiver
//   cannot stall, so each result must be taken in that cycle.
//   Steps: a lookup reads the bucket head, then visits the chain nodes one
//   by one (write, read, remove, contains key). A write then passes a growth
//   check; an insert adds an allocation step if it reuses a freed node, then
//   an insert step; a remove hit adds an unlink step. A write that triggers
//   growth adds a pass over every old bucket, splitting each chain into a
//   low and a high list. Contains value walks the buckets and chains in
//   order until a match, one entry per cycle. Back to back, the back takes
//   the next queued item while done shows the previous result.
//   Reset and every cfg_we write start a clearing pass over the bucket head
//   memory; busy stays high during it. cfg_wdata sets the log2 of the
//   starting bucket count, capped at 11, and empties the map.
module chained_hash_map_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  chm_pkg::item_t   item,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_wdata,
    output logic             done,
    output chm_pkg::result_t result
);
    import chm_pkg::*;

    fq_t fq;
    bk_t bk;

    chm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .bk    (bk),
        .fq    (fq)
    );

    chm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fq        (fq),
        .bk        (bk),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    // no result while the head memory is being cleared
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bk.clearing |-> !done)
        else $error("result during clearing pass");

    // stored count never exceeds the pool
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count <= 11'(MAX_ENTRIES)))
        else $error("entry count beyond pool");

    // capacity is always a power of two
    a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot(result.bucket_capacity))
        else $error("capacity not a power of two");

    // a pop only happens when the queue holds an entry
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bk.pop |-> fq.valid)
        else $error("pop of empty queue");
`endif

endmodule

@@ rtl/core/chm_front.sv @@
// Front end: takes operation transfers, classifies them and queues them.
// Depends on chm_pkg.
module chm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  chm_pkg::item_t item,
    output logic          busy,
    input  chm_pkg::bk_t   bk,
    output chm_pkg::fq_t   fq
);
    import chm_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       cls;

    // classify the operation code
    always_comb
    begin
        cls.key = item.key;
        cls.val = item.data_value;
        unique case (item.op)
            OP_WRITE:  cls.kind = K_WRITE;
            OP_READ:   cls.kind = K_READ;
            OP_REMOVE: cls.kind = K_REMOVE;
            OP_CKEY:   cls.kind = K_CKEY;
            OP_CVAL:   cls.kind = K_CVAL;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign busy = (cnt_reg == 2'd2) || bk.clearing;
    assign push = start && !busy;

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ bk.pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(bk.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    assign fq.valid = (cnt_reg != 2'd0);
    assign fq.cmd   = q_mem[rd_ptr_reg];

endmodule

@@ rtl/core/chm_back.sv @@
// Back end: bucket and node memories, chain walks, insert, remove, growth.
// Depends on chm_pkg.
module chm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_wdata,
    input  chm_pkg::fq_t     fq,
    output chm_pkg::bk_t     bk,
    output logic            done,
    output chm_pkg::result_t result
);
    import chm_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_HEAD  = 5'd2;
    localparam logic [4:0] S_NODE  = 5'd3;
    localparam logic [4:0] S_ALLOC = 5'd4;
    localparam logic [4:0] S_INS   = 5'd5;
    localparam logic [4:0] S_REM2  = 5'd6;
    localparam logic [4:0] S_GCHK  = 5'd7;
    localparam logic [4:0] S_GHEAD = 5'd8;
    localparam logic [4:0] S_GNODE = 5'd9;
    localparam logic [4:0] S_GWR1  = 5'd10;
    localparam logic [4:0] S_GWR2  = 5'd11;
    localparam logic [4:0] S_VHEAD = 5'd12;
    localparam logic [4:0] S_VNODE = 5'd13;

    // memories
    logic [PTR_W-1:0] head_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] key_mem  [MAX_ENTRIES];
    logic [VAL_W-1:0] val_mem  [MAX_ENTRIES];
    logic [PTR_W-1:0] link_mem [MAX_ENTRIES];
    logic [PTR_W-1:0] head_q, link_q;
    logic [KEY_W-1:0] key_q;
    logic [VAL_W-1:0] val_q;

    logic [BKT_AW-1:0]  head_ra, head_wa;
    logic [PTR_W-1:0]   head_wd;
    logic               head_we;
    logic [NODE_AW-1:0] node_ra, node_wa;
    logic               key_we, val_we, link_we;
    logic [PTR_W-1:0]   link_wd;
    logic [NODE_AW-1:0] link_wa;
    logic               q_pop;

    // control state
    logic [4:0]        st_reg, st_next;
    cmd_t              cmd_reg, cmd_next;
    logic [LOG_W-1:0]  log_reg, log_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  fresh_reg, fresh_next;
    logic [PTR_W-1:0]  rec_reg, rec_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]  prev_reg, prev_next;
    logic [BKT_AW-1:0] bidx_reg, bidx_next;
    logic [PTR_W-1:0]  bhead_reg, bhead_next;
    logic [PTR_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [BKT_AW-1:0] clr_reg, clr_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [VAL_W-1:0]  data_reg, data_next;
    logic [1:0]        stat_reg, stat_next;

    logic [BKT_AW-1:0] mask, cap_bit;
    logic [CAP_W-1:0]  cap;
    logic [CAP_W:0]    thr;
    logic              grow_ok, last_bkt;

    assign cap      = CAP_W'(1) << log_reg;
    assign mask     = BKT_AW'(cap - CAP_W'(1));
    assign cap_bit  = BKT_AW'(cap);
    assign thr      = {1'b0, cap >> 1} + {1'b0, cap >> 2} - {1'b0, cap >> 3};
    assign grow_ok  = ({2'b00, cnt_reg} > thr) && (log_reg < LOG2_MAX);
    assign last_bkt = (bidx_reg == mask);

    // memory ports: registered reads, one write per memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_q <= head_mem[head_ra];
        if (key_we)
        begin
            key_mem[node_wa] <= cmd_reg.key;
        end
        if (val_we)
        begin
            val_mem[node_wa] <= cmd_reg.val;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        key_q  <= key_mem[node_ra];
        val_q  <= val_mem[node_ra];
        link_q <= link_mem[node_ra];
    end

    // sequencer
    always_comb
    begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        log_next   = log_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        rec_next   = rec_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        bidx_next  = bidx_reg;
        bhead_next = bhead_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        data_next  = data_reg;
        stat_next  = stat_reg;
        head_ra    = bidx_reg;
        head_we    = 1'b0;
        head_wa    = bidx_reg;
        head_wd    = NIL;
        node_ra    = cur_reg[NODE_AW-1:0];
        node_wa    = cur_reg[NODE_AW-1:0];
        key_we     = 1'b0;
        val_we     = 1'b0;
        link_we    = 1'b0;
        link_wa    = cur_reg[NODE_AW-1:0];
        link_wd    = NIL;
        q_pop      = 1'b0;

        unique case (st_reg)
            S_CLEAR:
            begin
                head_we  = 1'b1;
                head_wa  = clr_reg;
                clr_next = clr_reg + BKT_AW'(1);
                if (clr_reg == BKT_AW'(MAX_BUCKETS - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (fq.valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = fq.cmd;
                    found_next = 1'b0;
                    data_next  = '0;
                    stat_next  = ST_OK;
                    case (fq.cmd.kind)
                        K_WRITE, K_READ, K_REMOVE, K_CKEY:
                        begin
                            bidx_next = fq.cmd.key[BKT_AW-1:0] & mask;
                            head_ra   = fq.cmd.key[BKT_AW-1:0] & mask;
                            st_next   = S_HEAD;
                        end
                        K_CVAL:
                        begin
                            bidx_next = '0;
                            head_ra   = '0;
                            st_next   = S_VHEAD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_HEAD, S_NODE:
            begin
                logic [PTR_W-1:0] nxt;
                logic             hit;
                nxt = (st_reg == S_HEAD) ? head_q : link_q;
                hit = (st_reg == S_NODE) && (key_q == cmd_reg.key);
                if (st_reg == S_HEAD)
                begin
                    bhead_next = head_q;
                    prev_next  = NIL;
                end
                if (hit)
                begin
                    unique case (cmd_reg.kind)
                        K_WRITE:
                        begin
                            val_we  = 1'b1;
                            st_next = S_GCHK;
                        end
                        K_READ:
                        begin
                            found_next = 1'b1;
                            data_next  = val_q;
                            done_next  = 1'b1;
                            st_next    = S_IDLE;
                        end
                        K_REMOVE:
                        begin
                            // unlink from predecessor or from bucket head
                            found_next = 1'b1;
                            if (prev_reg == NIL)
                            begin
                                head_we = 1'b1;
                                head_wd = link_q;
                            end
                            else
                            begin
                                link_we = 1'b1;
                                link_wa = prev_reg[NODE_AW-1:0];
                                link_wd = link_q;
                            end
                            st_next = S_REM2;
                        end
                        default:
                        begin
                            found_next = 1'b1;
                            done_next  = 1'b1;
                            st_next    = S_IDLE;
                        end
                    endcase
                end
                else if (nxt == NIL)
                begin
                    // key absent
                    unique case (cmd_reg.kind)
                        K_WRITE:
                        begin
                            if (cnt_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                stat_next = ST_FULL;
                                st_next   = S_GCHK;
                            end
                            else if (rec_reg != NIL)
                            begin
                                cur_next = rec_reg;
                                node_ra  = rec_reg[NODE_AW-1:0];
                                st_next  = S_ALLOC;
                            end
                            else
                            begin
                                cur_next   = fresh_reg;
                                fresh_next = fresh_reg + PTR_W'(1);
                                st_next    = S_INS;
                            end
                        end
                        K_READ:
                        begin
                            stat_next = ST_ABSENT;
                            done_next = 1'b1;
                            st_next   = S_IDLE;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            st_next   = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    if (st_reg == S_NODE)
                    begin
                        prev_next = cur_reg;
                    end
                    cur_next = nxt;
                    node_ra  = nxt[NODE_AW-1:0];
                    st_next  = S_NODE;
                end
            end
            S_ALLOC:
            begin
                rec_next = link_q;
                st_next  = S_INS;
            end
            S_INS:
            begin
                key_we   = 1'b1;
                val_we   = 1'b1;
                link_we  = 1'b1;
                link_wd  = bhead_reg;
                head_we  = 1'b1;
                head_wd  = cur_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                st_next  = S_GCHK;
            end
            S_REM2:
            begin
                link_we   = 1'b1;
                link_wd   = rec_reg;
                rec_next  = cur_reg;
                cnt_next  = cnt_reg - CNT_W'(1);
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            S_GCHK:
            begin
                if (grow_ok)
                begin
                    bidx_next = '0;
                    head_ra   = '0;
                    st_next   = S_GHEAD;
                end
                else
                begin
                    done_next = 1'b1;
                    st_next   = S_IDLE;
                end
            end
            S_GHEAD, S_GWR2:
            begin
                logic adv;
                adv = (st_reg == S_GWR2) || (head_q == NIL);
                if (st_reg == S_GWR2)
                begin
                    head_we = 1'b1;
                    head_wa = bidx_reg | cap_bit;
                    head_wd = hi_reg;
                end
                if (adv)
                begin
                    if (last_bkt)
                    begin
                        log_next  = log_reg + LOG_W'(1);
                        done_next = 1'b1;
                        st_next   = S_IDLE;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + BKT_AW'(1);
                        head_ra   = bidx_reg + BKT_AW'(1);
                        st_next   = S_GHEAD;
                    end
                end
                else
                begin
                    lo_next  = NIL;
                    hi_next  = NIL;
                    cur_next = head_q;
                    node_ra  = head_q[NODE_AW-1:0];
                    st_next  = S_GNODE;
                end
            end
            S_GNODE:
            begin
                // split by the next key bit: prepend to low or high list
                link_we = 1'b1;
                if (key_q[log_reg])
                begin
                    link_wd = hi_reg;
                    hi_next = cur_reg;
                end
                else
                begin
                    link_wd = lo_reg;
                    lo_next = cur_reg;
                end
                if (link_q == NIL)
                begin
                    st_next = S_GWR1;
                end
                else
                begin
                    cur_next = link_q;
                    node_ra  = link_q[NODE_AW-1:0];
                end
            end
            S_GWR1:
            begin
                head_we = 1'b1;
                head_wd = lo_reg;
                st_next = S_GWR2;
            end
            S_VHEAD, S_VNODE:
            begin
                logic [PTR_W-1:0] nxt;
                nxt = (st_reg == S_VHEAD) ? head_q : link_q;
                if ((st_reg == S_VNODE) && (val_q == cmd_reg.val))
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    st_next    = S_IDLE;
                end
                else if (nxt == NIL)
                begin
                    if (last_bkt)
                    begin
                        done_next = 1'b1;
                        st_next   = S_IDLE;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + BKT_AW'(1);
                        head_ra   = bidx_reg + BKT_AW'(1);
                        st_next   = S_VHEAD;
                    end
                end
                else
                begin
                    cur_next = nxt;
                    node_ra  = nxt[NODE_AW-1:0];
                    st_next  = S_VNODE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        // register write empties the map
        if (cfg_we)
        begin
            st_next    = S_CLEAR;
            clr_next   = '0;
            log_next   = (cfg_wdata > LOG2_MAX) ? LOG2_MAX : cfg_wdata;
            cnt_next   = '0;
            fresh_next = '0;
            rec_next   = NIL;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            clr_reg   <= '0;
            log_reg   <= LOG_W'(4);
            cnt_reg   <= '0;
            fresh_reg <= '0;
            rec_reg   <= NIL;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            clr_reg   <= clr_next;
            log_reg   <= log_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            rec_reg   <= rec_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        bidx_reg  <= bidx_next;
        bhead_reg <= bhead_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        found_reg <= found_next;
        data_reg  <= data_next;
        stat_reg  <= stat_next;
    end

    assign bk   = '{pop: q_pop, clearing: (st_reg == S_CLEAR)};
    assign done = done_reg;

    assign result.found           = found_reg;
    assign result.read_data       = data_reg;
    assign result.status          = stat_reg;
    assign result.entry_count     = cnt_reg;
    assign result.bucket_capacity = cap;

endmodule
